/* design/utfr_pkg.sv */
package utfr_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [1:0] LEAD_C2 = 2'd0;
    localparam logic [1:0] LEAD_EF = 2'd1;
    localparam logic [1:0] LEAD_E2 = 2'd2;

    localparam logic [7:0] B_C2 = 8'hC2;
    localparam logic [7:0] B_A0 = 8'hA0;
    localparam logic [7:0] B_EF = 8'hEF;
    localparam logic [7:0] B_BB = 8'hBB;
    localparam logic [7:0] B_BF = 8'hBF;
    localparam logic [7:0] B_E2 = 8'hE2;
    localparam logic [7:0] B_80 = 8'h80;
    localparam logic [7:0] B_88 = 8'h88;
    localparam logic [7:0] B_92 = 8'h92;
    localparam logic [7:0] B_93 = 8'h93;
    localparam logic [7:0] B_94 = 8'h94;
    localparam logic [7:0] B_98 = 8'h98;
    localparam logic [7:0] B_99 = 8'h99;
    localparam logic [7:0] B_9B = 8'h9B;
    localparam logic [7:0] B_9C = 8'h9C;
    localparam logic [7:0] B_9D = 8'h9D;
    localparam logic [7:0] B_A6 = 8'hA6;

    localparam logic [6:0] CH_NUL   = 7'h00;
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_NL    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DQUOTE = 7'h22;
    localparam logic [6:0] CH_QUOTE = 7'h27;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_QMARK = 7'h3F;

    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int QCNT_BITS = 3;

    typedef enum logic [1:0] {
        QK_START,
        QK_CHAR,
        QK_END
    } qkind_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  text_char;
        logic [31:0] out_pos;
        logic        end_of_text;
        logic        last;
    } out_item_t;

    typedef struct packed {
        qkind_t      kind;
        logic [6:0]  ch;
        logic [31:0] pos;
        logic        has_q;
        logic [31:0] qpos;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* design/utfr_front.sv */
module utfr_front
    import utfr_pkg::*;
#(
    parameter int POS_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  in_item_t    item,
    input  logic [31:0] start_offset,
    input  q_status_t   q_status,
    output logic        item_stall,
    output logic        push,
    output q_entry_t    push_entry
);

    logic [POS_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [POS_BITS-1:0] lead_pos_reg, lead_pos_next;
    logic [1:0]          trail_reg, trail_next;
    logic [1:0]          kind_reg, kind_next;
    logic [7:0]          first_reg, first_next;
    logic                accept;
    logic [7:0]          b;

    function automatic logic [6:0] fold_e2(input logic [7:0] b1, input logic [7:0] b2);
        logic [6:0] c;
        c = CH_QMARK;
        if (b1 == B_80) begin
            if (b2 inside {B_93, B_94})
                c = CH_DASH;
            else if (b2 inside {B_98, B_99, B_9B})
                c = CH_QUOTE;
            else if (b2 inside {B_9C, B_9D})
                c = CH_DQUOTE;
            else if (b2 == B_A6)
                c = CH_DOT;
        end
        else if (b1 == B_88 && b2 == B_92) begin
            c = CH_DASH;
        end
        return c;
    endfunction

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;
    assign b          = item.data_byte;

    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        lead_pos_next = lead_pos_reg;
        trail_next    = trail_reg;
        kind_next     = kind_reg;
        first_next    = first_reg;
        push          = 1'b0;
        push_entry    = '0;
        push_entry.kind = QK_CHAR;
        if (accept)
        begin
            case (item.opcode)
                OP_START:
                begin
                    byte_pos_next   = POS_BITS'(start_offset);
                    lead_pos_next   = '0;
                    trail_next      = 2'd0;
                    kind_next       = LEAD_C2;
                    first_next      = 8'd0;
                    push            = 1'b1;
                    push_entry.kind = QK_START;
                end
                OP_END:
                begin
                    push             = 1'b1;
                    push_entry.kind  = QK_END;
                    push_entry.has_q = (trail_reg != 2'd0);
                    push_entry.qpos  = 32'(lead_pos_reg);
                    push_entry.pos   = 32'(byte_pos_reg);
                    lead_pos_next    = '0;
                    trail_next       = 2'd0;
                    kind_next        = LEAD_C2;
                    first_next       = 8'd0;
                end
                OP_DATA:
                begin
                    byte_pos_next = byte_pos_reg + POS_BITS'(1);
                    if (trail_reg == 2'd0)
                    begin
                        push_entry.pos = 32'(byte_pos_reg);
                        if (!b[7])
                        begin
                            // drop CR here, it never reaches the reflow
                            push          = (b[6:0] != CH_CR);
                            push_entry.ch = b[6:0];
                        end
                        else if (b == B_C2)
                        begin
                            kind_next     = LEAD_C2;
                            trail_next    = 2'd1;
                            lead_pos_next = byte_pos_reg;
                        end
                        else if (b == B_EF || b == B_E2)
                        begin
                            kind_next     = (b == B_EF) ? LEAD_EF : LEAD_E2;
                            trail_next    = 2'd2;
                            lead_pos_next = byte_pos_reg;
                        end
                        else
                        begin
                            push          = 1'b1;
                            push_entry.ch = CH_QMARK;
                        end
                    end
                    else if (kind_reg == LEAD_C2)
                    begin
                        trail_next     = 2'd0;
                        push           = 1'b1;
                        push_entry.pos = 32'(lead_pos_reg);
                        push_entry.ch  = (b == B_A0) ? CH_SPACE : CH_QMARK;
                    end
                    else if (trail_reg[1])
                    begin
                        first_next = b;
                        trail_next = 2'd1;
                    end
                    else
                    begin
                        trail_next     = 2'd0;
                        push_entry.pos = 32'(lead_pos_reg);
                        if (kind_reg == LEAD_EF)
                        begin
                            // drop a byte-order mark only when its lead byte is at position zero
                            push = !(lead_pos_reg == '0 && first_reg == B_BB && b == B_BF);
                            push_entry.ch = CH_QMARK;
                        end
                        else if (kind_reg == LEAD_E2)
                        begin
                            push          = 1'b1;
                            push_entry.ch = fold_e2(first_reg, b);
                        end
                        else
                        begin
                            push          = 1'b1;
                            push_entry.ch = CH_QMARK;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            lead_pos_reg <= '0;
            trail_reg    <= 2'd0;
            kind_reg     <= LEAD_C2;
            first_reg    <= 8'd0;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
            lead_pos_reg <= lead_pos_next;
            trail_reg    <= trail_next;
            kind_reg     <= kind_next;
            first_reg    <= first_next;
        end
    end

`ifndef SYNTHESIS
    a_trail_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (trail_reg == 2'd2) |-> (kind_reg == LEAD_EF || kind_reg == LEAD_E2))
        else $error("two trail bytes owed to a two-byte lead");
`endif

endmodule

/* design/utfr_fifo.sv */
module utfr_fifo
    import utfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    q_entry_t              mem [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_BITS'(QDEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            count_reg <= count_reg + QCNT_BITS'(push) - QCNT_BITS'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("queue read while empty");
`endif

endmodule

/* design/utfr_back.sv */
module utfr_back
    import utfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_entry_t  head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic [1:0] nl_run_reg;
    logic       sp_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    out_item_t  res [4];
    logic [1:0] cnt;
    logic       is_nl;
    logic       is_ws;
    logic       vis_en;
    logic [6:0] vis_ch;
    logic [31:0] vis_pos;
    logic       load;
    logic       at_last;
    out_item_t  load_item;
    logic [1:0] nl_run_next;
    logic       sp_next;

    assign is_nl = (head.ch == CH_NL);
    assign is_ws = (head.ch == CH_SPACE || head.ch == CH_TAB);

    always_comb
    begin
        res[0] = '0;
        res[1] = '0;
        res[2] = '0;
        res[3] = '0;
        cnt    = 2'd0;
        vis_en  = (head.kind == QK_CHAR && !is_nl && !is_ws) ||
                  (head.kind == QK_END && head.has_q);
        vis_ch  = (head.kind == QK_END) ? CH_QMARK : head.ch;
        vis_pos = (head.kind == QK_END) ? head.qpos : head.pos;

        // break before a visible character: paragraph or single space
        if (vis_en && (nl_run_reg != 2'd0 || sp_reg))
        begin
            res[cnt].text_char = nl_run_reg[1] ? CH_NL : CH_SPACE;
            res[cnt].out_pos   = vis_pos;
            cnt = cnt + 2'd1;
        end
        // blank after a paragraph break: emit the break alone
        if (head.kind == QK_CHAR && is_ws && nl_run_reg[1])
        begin
            res[cnt].text_char = CH_NL;
            res[cnt].out_pos   = head.pos;
            cnt = cnt + 2'd1;
        end
        if (vis_en)
        begin
            res[cnt].text_char = vis_ch;
            res[cnt].out_pos   = vis_pos;
            cnt = cnt + 2'd1;
        end
        if (head.kind == QK_END)
        begin
            res[cnt].text_char   = CH_NUL;
            res[cnt].out_pos     = head.pos;
            res[cnt].end_of_text = 1'b1;
            cnt = cnt + 2'd1;
        end

        nl_run_next = 2'd0;
        sp_next     = 1'b0;
        if (head.kind == QK_CHAR)
        begin
            if (is_nl)
            begin
                nl_run_next = nl_run_reg[1] ? nl_run_reg : nl_run_reg + 2'd1;
                sp_next     = sp_reg;
            end
            else if (is_ws)
            begin
                sp_next = !nl_run_reg[1];
            end
        end
    end

    assign at_last = (idx_reg == cnt - 2'd1);
    assign load    = !q_status.empty && cnt != 2'd0 && (!out_valid_reg || !result_stall);
    assign pop     = !q_status.empty && (cnt == 2'd0 || (load && at_last));

    always_comb
    begin
        load_item      = res[idx_reg];
        load_item.last = at_last;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= load_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_run_reg    <= 2'd0;
            sp_reg        <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            if (pop)
            begin
                idx_reg    <= 2'd0;
                nl_run_reg <= nl_run_next;
                sp_reg     <= sp_next;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> !q_status.empty)
        else $error("result sequence in progress without a queue entry");
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.end_of_text) |-> (out_reg.last && out_reg.text_char == CH_NUL))
        else $error("end marker not the closing result");
    a_nl_sat: assert property (@(posedge clk) disable iff (!rst_n)
        nl_run_reg != 2'd3)
        else $error("newline run past saturation");
`endif

endmodule

/* design/utf8_fold_and_text_reflow.sv */
// An item's queue entry is written at its input transfer; its first result is then loaded
// into the output register once that entry is at the queue head and result_stall is low.
// Throughput: 1 input item per cycle while each item yields at most one result and
// result_stall is low; an item with more results holds the output sequencer until all are
// out, and a 4-entry queue between decoder and reflow sequencer absorbs the difference.
// Reset (rst_n, asynchronous, active low) clears position, decoder, reflow and queue state.
module utf8_fold_and_text_reflow
    import utfr_pkg::*;
#(
    parameter int POS_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result
);

    logic [31:0] start_offset_reg;
    logic        push;
    q_entry_t    push_entry;
    logic        pop;
    q_entry_t    head;
    q_status_t   q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_offset_reg <= 32'd0;
        else if (cfg_write_en)
            start_offset_reg <= cfg_write_data;
    end

    utfr_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .start_offset (start_offset_reg),
        .q_status     (q_status),
        .item_stall   (item_stall),
        .push         (push),
        .push_entry   (push_entry)
    );

    utfr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    utfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* dv/tb.sv */
module tb;
    import utfr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE = 4;
    localparam int END_WAIT = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 200;

    localparam logic [7:0] DIRECTED_TEXT [20] = '{
        B_EF, B_BB, B_BF, 8'h41, {1'b0, CH_SPACE}, {1'b0, CH_TAB}, 8'h62, {1'b0, CH_NL},
        8'h63, {1'b0, CH_CR}, {1'b0, CH_NL}, {1'b0, CH_NL}, {1'b0, CH_SPACE}, B_C2, B_A0,
        8'h64, B_E2, B_80, B_94, 8'hFF
    };
    localparam logic [7:0] E2_80_TAILS [8] = '{B_93, B_94, B_98, B_99, B_9B, B_9C, B_9D, B_A6};
    localparam logic [7:0] BLANKS [4] = '{
        {1'b0, CH_SPACE}, {1'b0, CH_TAB}, {1'b0, CH_NL}, {1'b0, CH_CR}
    };

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        in_item_t    item;
        logic [31:0] value;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [31:0] cfg_write_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    in_item_t    item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    out_item_t   result;

    utf8_fold_and_text_reflow dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] pred_offset = '0;
    logic [31:0] pred_pos = '0;
    logic [31:0] pred_lead_pos = '0;
    logic [1:0]  pred_trail = '0;
    logic [1:0]  pred_kind = LEAD_C2;
    logic [7:0]  pred_first = '0;
    logic [1:0]  pred_nl_run = '0;
    logic        pred_space = 1'b0;
    out_item_t   expected_chars[$];

    step_t steps[$];
    int    stim_items = 0;
    int    mismatches = 0;
    int    cycle_count = 0;
    int    idle_cycles = 0;
    int    gap_left = 0;
    int    hold_left = 0;
    logic  item_fire = 1'b0;
    logic  result_fire = 1'b0;
    logic  tx_calm = 1'b0;
    logic  rx_calm = 1'b0;

    task automatic emit_char(input logic [6:0] ch, input logic [31:0] pos, input logic eot);
        out_item_t r;
        r.text_char = ch;
        r.out_pos = pos;
        r.end_of_text = eot;
        r.last = 1'b0;
        expected_chars.push_back(r);
    endtask

    task automatic reflow_char(input logic [6:0] c, input logic [31:0] pos);
        if (c == CH_NL) begin
            if (pred_nl_run < 2'd2)
                pred_nl_run = pred_nl_run + 2'd1;
        end
        else if (c == CH_SPACE || c == CH_TAB) begin
            if (pred_nl_run >= 2'd2) begin
                pred_nl_run = '0;
                pred_space = 1'b0;
                emit_char(CH_NL, pos, 1'b0);
            end
            else begin
                pred_space = 1'b1;
                pred_nl_run = '0;
            end
        end
        else if (c != CH_CR) begin
            if (pred_nl_run >= 2'd2)
                emit_char(CH_NL, pos, 1'b0);
            else if (pred_nl_run == 2'd1 || pred_space)
                emit_char(CH_SPACE, pos, 1'b0);
            pred_nl_run = '0;
            pred_space = 1'b0;
            emit_char(c, pos, 1'b0);
        end
    endtask

    function automatic logic [6:0] e2_fold_char(input logic [7:0] b1, input logic [7:0] b2);
        if (b1 == B_80) begin
            if (b2 == B_93 || b2 == B_94)
                return CH_DASH;
            if (b2 == B_98 || b2 == B_99 || b2 == B_9B)
                return CH_QUOTE;
            if (b2 == B_9C || b2 == B_9D)
                return CH_DQUOTE;
            if (b2 == B_A6)
                return CH_DOT;
        end
        if (b1 == B_88 && b2 == B_92)
            return CH_DASH;
        return CH_QMARK;
    endfunction

    task automatic clear_decoder();
        pred_trail = '0;
        pred_kind = LEAD_C2;
        pred_first = '0;
        pred_lead_pos = '0;
        pred_nl_run = '0;
        pred_space = 1'b0;
    endtask

    task automatic fold_predict(input in_item_t it);
        int          count_in;
        logic [31:0] p;
        logic [7:0]  b;
        out_item_t   tail;
        count_in = expected_chars.size();
        b = it.data_byte;
        case (it.opcode)
            OP_START: begin
                clear_decoder();
                pred_pos = pred_offset;
            end
            OP_END: begin
                // a cut-off sequence still folds to a question mark
                if (pred_trail != 2'd0)
                    reflow_char(CH_QMARK, pred_lead_pos);
                clear_decoder();
                emit_char(CH_NUL, pred_pos, 1'b1);
            end
            OP_DATA: begin
                p = pred_pos;
                pred_pos = pred_pos + 32'd1;
                if (pred_trail == 2'd0) begin
                    if (!b[7])
                        reflow_char(b[6:0], p);
                    else if (b == B_C2) begin
                        pred_kind = LEAD_C2;
                        pred_trail = 2'd1;
                        pred_lead_pos = p;
                    end
                    else if (b == B_EF || b == B_E2) begin
                        pred_kind = (b == B_EF) ? LEAD_EF : LEAD_E2;
                        pred_trail = 2'd2;
                        pred_lead_pos = p;
                    end
                    else
                        reflow_char(CH_QMARK, p);
                end
                else if (pred_kind == LEAD_C2) begin
                    pred_trail = '0;
                    reflow_char((b == B_A0) ? CH_SPACE : CH_QMARK, pred_lead_pos);
                end
                else if (pred_trail >= 2'd2) begin
                    pred_first = b;
                    pred_trail = 2'd1;
                end
                else begin
                    pred_trail = '0;
                    if (pred_kind == LEAD_EF) begin
                        // drop a byte-order mark only at position zero
                        if (!(pred_lead_pos == '0 && pred_first == B_BB && b == B_BF))
                            reflow_char(CH_QMARK, pred_lead_pos);
                    end
                    else
                        reflow_char(e2_fold_char(pred_first, b), pred_lead_pos);
                end
            end
            default: ;
        endcase
        if (expected_chars.size() > count_in) begin
            tail = expected_chars.pop_back();
            tail.last = 1'b1;
            expected_chars.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic push_op(input logic [1:0] op, input logic [7:0] b);
        step_t s;
        s.kind = STEP_ITEM;
        s.item.opcode = op;
        s.item.data_byte = b;
        s.value = '0;
        steps.push_back(s);
        stim_items++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_op(OP_DATA, b);
    endtask

    task automatic push_ctrl(input step_kind_t kind, input logic [31:0] value);
        step_t s;
        s.kind = kind;
        s.item = '0;
        s.value = value;
        steps.push_back(s);
    endtask

    task automatic add_random_chunk();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick <= 5) begin
            repeat ($urandom_range(1, 4))
                push_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
        else if (pick <= 8) begin
            repeat ($urandom_range(1, 3))
                push_byte(BLANKS[2'($urandom_range(0, 3))]);
        end
        else if (pick == 9) begin
            push_byte(B_C2);
            push_byte(B_A0);
        end
        else if (pick <= 11) begin
            push_byte(B_E2);
            push_byte(B_80);
            push_byte(E2_80_TAILS[3'($urandom_range(0, 7))]);
        end
        else if (pick == 12) begin
            push_byte(B_E2);
            push_byte(B_88);
            push_byte(B_92);
        end
        else if (pick == 13) begin
            push_byte(B_EF);
            push_byte(B_BB);
            push_byte(B_BF);
        end
        else if (pick == 14) begin
            push_byte(B_C2);
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (pick == 15) begin
            push_byte($urandom_range(0, 1) ? B_E2 : B_EF);
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (pick == 16) begin
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (pick == 17) begin
            push_byte(8'($urandom_range(0, 127)));
        end
        else if (pick == 18) begin
            push_op(OP_UNUSED, 8'($urandom_range(0, 255)));
        end
        else begin
            // restart in the middle of a stream
            push_op(OP_START, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        logic [31:0] offset;
        int          sel;

        push_ctrl(STEP_CFG, '0);
        push_op(OP_START, 8'($urandom_range(0, 255)));
        foreach (DIRECTED_TEXT[i])
            push_byte(DIRECTED_TEXT[i]);
        push_op(OP_UNUSED, 8'($urandom_range(0, 255)));
        push_byte(B_E2);
        push_byte(B_80);
        // hold the sender until every pending result is out
        push_ctrl(STEP_DRAIN, '0);
        push_op(OP_END, 8'($urandom_range(0, 255)));

        while (stim_items < ITEM_TARGET) begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: offset = '0;
                1: offset = '1;
                2: offset = 32'hFFFF_FFFF - $urandom_range(0, 6);
                3: offset = $urandom;
                4: offset = $urandom_range(0, 3);
                default: offset = {1'($urandom_range(0, 1)), 31'h0} | $urandom_range(0, 255);
            endcase
            push_ctrl(STEP_CFG, offset);
            push_op(OP_START, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(4, 12)) begin
                add_random_chunk();
                if ($urandom_range(0, 15) == 0)
                    push_ctrl(STEP_DRAIN, '0);
            end
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    sel = $urandom_range(0, 2);
                    push_byte(sel == 0 ? B_C2 : (sel == 1 ? B_E2 : B_EF));
                    if (sel != 0 && $urandom_range(0, 1))
                        push_byte(8'($urandom_range(0, 255)));
                end
                push_op(OP_END, 8'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
    end

    // sender: at most one step per falling edge, none while an item is pending or a gap runs; gap drawn per transfer
    always @(negedge clk) begin : driver
        logic        valid_next;
        in_item_t    item_next;
        logic        wr_next;
        logic [31:0] data_next;
        if (rst_n) begin
            if ($urandom_range(0, 49) == 0)
                tx_calm = !tx_calm;
            valid_next = item_valid;
            item_next = item;
            wr_next = 1'b0;
            data_next = cfg_write_data;
            if (item_valid && item_fire)
                valid_next = 1'b0;
            if (!valid_next) begin
                if (gap_left > 0)
                    gap_left--;
                else if (steps.size() != 0) begin
                    if (steps[0].kind == STEP_ITEM) begin
                        valid_next = 1'b1;
                        item_next = steps[0].item;
                        void'(steps.pop_front());
                        gap_left = tx_calm ? 0 : $urandom_range(0, 7);
                    end
                    else if (expected_chars.size() == 0 && idle_cycles >= SETTLE) begin
                        if (steps[0].kind == STEP_CFG) begin
                            wr_next = 1'b1;
                            data_next = steps[0].value;
                        end
                        void'(steps.pop_front());
                    end
                end
            end
            item_valid <= valid_next;
            item <= item_next;
            cfg_write_en <= wr_next;
            cfg_write_data <= data_next;
        end
    end

    // receiver: stall drawn per result transfer
    always @(negedge clk) begin : sink
        if (rst_n) begin
            if ($urandom_range(0, 49) == 0)
                rx_calm = !rx_calm;
            if (result_fire)
                hold_left = rx_calm ? 0 : $urandom_range(0, 7);
            result_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    always @(posedge clk) begin : monitor
        out_item_t want;
        if (rst_n) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb failed");
                $finish;
            end
            else begin
                if (cfg_write_en)
                    pred_offset = cfg_write_data;
                if (result_valid && !result_stall) begin
                    if (expected_chars.size() == 0)
                        report_mismatch($sformatf("unexpected result char %h pos %h eot %b",
                            result.text_char, result.out_pos, result.end_of_text));
                    else begin
                        want = expected_chars.pop_front();
                        if (result.text_char !== want.text_char)
                            report_mismatch($sformatf("text_char %h, want %h (pos %h)",
                                result.text_char, want.text_char, want.out_pos));
                        if (result.out_pos !== want.out_pos)
                            report_mismatch($sformatf("out_pos %h, want %h",
                                result.out_pos, want.out_pos));
                        if (result.end_of_text !== want.end_of_text)
                            report_mismatch($sformatf("end_of_text %b, want %b (pos %h)",
                                result.end_of_text, want.end_of_text, want.out_pos));
                        if (result.last !== want.last)
                            report_mismatch($sformatf("last %b, want %b (pos %h)",
                                result.last, want.last, want.out_pos));
                    end
                end
                if (item_valid && !item_stall)
                    fold_predict(item);
                item_fire <= item_valid && !item_stall;
                result_fire <= result_valid && !result_stall;
                if (item_valid || result_valid || expected_chars.size() != 0)
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (steps.size() == 0 && !item_valid && expected_chars.size() == 0
                        && idle_cycles >= END_WAIT) begin
                    if (mismatches == 0)
                        $display("tb passed");
                    else
                        $display("tb failed");
                    $finish;
                end
            end
        end
    end

endmodule

/* utf8_fold_and_text_reflow.f */
design/utfr_pkg.sv
design/utfr_front.sv
design/utfr_fifo.sv
design/utfr_back.sv
design/utf8_fold_and_text_reflow.sv
dv/tb.sv
